// ===== rtl/bpj_pkg.sv =====
package bpj_pkg;

   localparam int RIGHT_CAPACITY = 64;
   localparam int COORD_BITS = 32;
   localparam int IDX_BITS = 6;
   localparam int CNT_BITS = 7;

   localparam logic [2:0] INTER = 3'd0;
   localparam logic [2:0] DISJO = 3'd1;
   localparam logic [2:0] EQUAL = 3'd2;
   localparam logic [2:0] OVERL = 3'd3;
   localparam logic [2:0] WITHI = 3'd4;

   localparam logic [1:0] R = 2'd0;
   localparam logic [1:0] L = 2'd1;
   localparam logic [1:0] OP_NEW_TILE = 2'd2;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] xlo;
      logic signed [COORD_BITS-1:0] ylo;
      logic signed [COORD_BITS-1:0] xhi;
      logic signed [COORD_BITS-1:0] yhi;
   } box_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // per-cell evaluation result
   typedef struct packed {
      logic match;
      logic valid;
   } cell_res_type;

   function automatic logic ax_within(logic signed [COORD_BITS-1:0] a0,
                                      logic signed [COORD_BITS-1:0] a1,
                                      logic signed [COORD_BITS-1:0] b0,
                                      logic signed [COORD_BITS-1:0] b1);
      return (b0 <= a0) && (a1 <= b1) && ((b0 < a1) || ((b0 == a0) && (a0 == a1)));
   endfunction

   function automatic logic test_pair(box_type a, box_type b, logic [2:0] mode);
      logic inter, open_meet, a_in_b, b_in_a, res;
      inter = (a.xlo <= b.xhi) && (b.xlo <= a.xhi) &&
              (a.ylo <= b.yhi) && (b.ylo <= a.yhi);
      open_meet = (a.xlo < b.xhi) && (a.xhi > b.xlo) &&
                  (a.ylo < b.yhi) && (a.yhi > b.ylo);
      a_in_b = (a.xlo >= b.xlo) && (a.xhi <= b.xhi) &&
               (a.ylo >= b.ylo) && (a.yhi <= b.yhi);
      b_in_a = (b.xlo >= a.xlo) && (b.xhi <= a.xhi) &&
               (b.ylo >= a.ylo) && (b.yhi <= a.yhi);
      case (mode)
         INTER:   res = inter;
         DISJO:   res = !inter;
         EQUAL:   res = (a == b);
         OVERL:   res = open_meet && !a_in_b && !b_in_a;
         WITHI:   res = ax_within(a.xlo, a.xhi, b.xlo, b.xhi) &&
                        ax_within(a.ylo, a.yhi, b.ylo, b.yhi);
         default: res = 1'b0;
      endcase
      return res;
   endfunction

endpackage

// ===== rtl/bpj_cell.sv =====
// One slot of the right-box chain. During a scan the row rotates by one
// each cycle; the head cell (index 0) presents its box to the comparator.
module bpj_cell (
   input  logic              clock,
   input  logic              load,
   input  logic              shift,
   input  bpj_pkg::box_type  load_box,
   input  bpj_pkg::box_type  prev_box,
   output bpj_pkg::box_type  box
);

   bpj_pkg::box_type box_ff, box_in;

   always_comb begin
      box_in = box_ff;
      if (load) begin
         box_in = load_box;
      end else if (shift) begin
         box_in = prev_box;
      end
   end

   always_ff @(posedge clock) begin
      box_ff <= box_in;
   end

   assign box = box_ff;

endmodule

// ===== rtl/bpj_eval.sv =====
// Registered predicate test of the probe box against the head of the chain.
module bpj_eval (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic [2:0]            mode,
   input  bpj_pkg::box_type      left_box,
   input  bpj_pkg::box_type      right_box,
   output bpj_pkg::cell_res_type res
);

   bpj_pkg::cell_res_type res_ff, res_in;

   always_comb begin
      res_in.valid = en;
      res_in.match = en && bpj_pkg::test_pair(left_box, right_box, mode);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
      end else begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ===== rtl/box_predicate_join.sv =====
// box_predicate_join: nested-loop join of bounding boxes within one tile.
// Requests: start with req_operation and the four req_ corners, taken when
// start is high and busy low. Load (0) stores a right box, probe (1) tests
// a left box against all stored right boxes, new tile (2) empties the store.
// Configuration: csr_we writes csr_predicate_mode; write only while idle.
// Results: one per hit, each shown for one cycle with rsp_valid; the
// receiver cannot stall. The last result of a probe has rsp_last_of_probe;
// a probe without hits gives one terminator with rsp_hit low.
// Stored boxes sit in a chain of cells whose filled part rotates one place
// per cycle during a probe's scan, so a probe walks the store through one
// comparator and leaves every box back in place.
// Sequence: load and new tile are handled while idle and never raise busy. A
// probe keeps busy high through its scan state, which rotates the store past
// the comparator, and its done state, which retires the last compare and issues
// the final result; its last result is on the ports in the first cycle with busy
// low. With an empty store the probe skips the scan. Each hit is held until the
// next hit or the finish, so hits come out in index order.
// Reset clears counts, overflow flag, mode and control; box store is not
// cleared and is read only below the fill count.
module box_predicate_join (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_operation,
   input  logic signed [31:0]  req_x_min,
   input  logic signed [31:0]  req_y_min,
   input  logic signed [31:0]  req_x_max,
   input  logic signed [31:0]  req_y_max,
   input  logic                csr_we,
   input  logic [2:0]          csr_predicate_mode,
   output logic                rsp_valid,
   output logic [15:0]         rsp_left_position,
   output logic [5:0]          rsp_right_position,
   output logic                rsp_hit,
   output logic                rsp_last_of_probe,
   output logic                rsp_store_overflow
);

   localparam int NC = bpj_pkg::RIGHT_CAPACITY;
   localparam int IB = bpj_pkg::IDX_BITS;
   localparam int CB = bpj_pkg::CNT_BITS;

   bpj_pkg::state_type state_ff, state_in;
   logic [CB-1:0] count_ff, count_in;
   logic [15:0] left_ff, left_in;
   logic ovf_ff, ovf_in;
   logic [2:0] mode_ff;
   logic [CB-1:0] step_ff, step_in;
   logic [IB-1:0] eidx_ff, eidx_in;
   bpj_pkg::box_type probe_ff, probe_in;
   logic any_ff, any_in;

   bpj_pkg::box_type req_box;
   bpj_pkg::box_type cell_box [NC];
   logic accept, do_load, do_shift, eval_en;
   bpj_pkg::cell_res_type res;

   // pending hit awaiting the next one, so last can be marked
   logic pend_ff, pend_in;
   logic [IB-1:0] pidx_ff, pidx_in;

   logic ov_ff, ov_in, oh_ff, oh_in, ol_ff, ol_in;
   logic [IB-1:0] oidx_ff, oidx_in;

   assign req_box = '{req_x_min[bpj_pkg::COORD_BITS-1:0], req_y_min[bpj_pkg::COORD_BITS-1:0],
                      req_x_max[bpj_pkg::COORD_BITS-1:0], req_y_max[bpj_pkg::COORD_BITS-1:0]};
   assign accept = start && !busy;
   assign busy = (state_ff != bpj_pkg::ST_IDLE);
   assign do_load = accept && (req_operation == bpj_pkg::R) &&
                    (count_ff < CB'(NC));
   assign do_shift = (state_ff == bpj_pkg::ST_SCAN);
   assign eval_en = do_shift;

   genvar g;
   generate
      for (g = 0; g < NC; g++) begin : g_cell
         // the last filled cell closes the ring back to the head
         bpj_cell u_cell (
            .clock    (clock),
            .load     (do_load && (count_ff[IB-1:0] == IB'(g))),
            .shift    (do_shift),
            .load_box (req_box),
            .prev_box ((count_ff == CB'(g + 1)) ? cell_box[0] : cell_box[(g + 1) % NC]),
            .box      (cell_box[g])
         );
      end
   endgenerate

   bpj_eval u_eval (
      .clock     (clock),
      .reset     (reset),
      .en        (eval_en),
      .mode      (mode_ff),
      .left_box  (probe_ff),
      .right_box (cell_box[0]),
      .res       (res)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      left_in = left_ff;
      ovf_in = ovf_ff;
      step_in = step_ff;
      eidx_in = eidx_ff;
      probe_in = probe_ff;
      any_in = any_ff;
      pend_in = pend_ff;
      pidx_in = pidx_ff;
      ov_in = 1'b0;
      oh_in = 1'b0;
      ol_in = 1'b0;
      oidx_in = oidx_ff;

      // compare result from previous cycle
      if (res.valid) begin
         eidx_in = eidx_ff + IB'(1);
         if (res.match) begin
            any_in = 1'b1;
            pend_in = 1'b1;
            pidx_in = eidx_ff;
            if (pend_ff) begin
               ov_in = 1'b1;
               oh_in = 1'b1;
               oidx_in = pidx_ff;
            end
         end
      end

      case (state_ff)
         bpj_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_operation)
                  bpj_pkg::R: begin
                     if (count_ff < CB'(NC)) begin
                        count_in = count_ff + CB'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  bpj_pkg::L: begin
                     probe_in = req_box;
                     step_in = '0;
                     eidx_in = '0;
                     any_in = 1'b0;
                     pend_in = 1'b0;
                     state_in = (count_ff == '0) ? bpj_pkg::ST_DONE : bpj_pkg::ST_SCAN;
                  end
                  bpj_pkg::OP_NEW_TILE: begin
                     count_in = '0;
                     left_in = '0;
                     ovf_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         bpj_pkg::ST_SCAN: begin
            step_in = step_ff + CB'(1);
            // full rotation: after count shifts, head returns to index 0
            if (step_ff == count_ff - CB'(1)) begin
               state_in = bpj_pkg::ST_DONE;
            end
         end
         bpj_pkg::ST_DONE: begin
            // last compare retired in previous cycle's res handling here
            if (!res.valid) begin
               ov_in = 1'b1;
               ol_in = 1'b1;
               if (pend_ff || (res.valid && res.match)) begin
                  oh_in = 1'b1;
                  oidx_in = pidx_ff;
               end else begin
                  oh_in = 1'b0;
                  oidx_in = '0;
               end
               pend_in = 1'b0;
               state_in = bpj_pkg::ST_IDLE;
               if (left_ff != 16'hFFFF) begin
                  left_in = left_ff + 16'd1;
               end
            end
         end
         default: state_in = bpj_pkg::ST_IDLE;
      endcase
   end

   // note: for a non-empty store the final compare result arrives in the first
   // DONE cycle; the last result of the probe is issued the cycle after.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpj_pkg::ST_IDLE;
         count_ff <= '0;
         left_ff <= '0;
         ovf_ff <= 1'b0;
         mode_ff <= bpj_pkg::INTER;
         pend_ff <= 1'b0;
         ov_ff <= 1'b0;
         any_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         left_ff <= left_in;
         ovf_ff <= ovf_in;
         pend_ff <= pend_in;
         ov_ff <= ov_in;
         any_ff <= any_in;
         if (csr_we) begin
            mode_ff <= csr_predicate_mode;
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      eidx_ff <= eidx_in;
      probe_ff <= probe_in;
      pidx_ff <= pidx_in;
      oh_ff <= oh_in;
      ol_ff <= ol_in;
      oidx_ff <= oidx_in;
   end

   logic [15:0] lpos_ff;
   logic sovf_ff;
   always_ff @(posedge clock) begin
      lpos_ff <= left_ff;
      sovf_ff <= ovf_ff;
   end

   assign rsp_valid = ov_ff;
   assign rsp_hit = oh_ff;
   assign rsp_last_of_probe = ol_ff;
   assign rsp_right_position = oidx_ff;
   assign rsp_left_position = lpos_ff;
   assign rsp_store_overflow = sovf_ff;

   a_no_result_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpj_pkg::ST_IDLE && $past(state_ff) == bpj_pkg::ST_IDLE &&
       !$past(reset)) |-> !res.valid)
      else $error("compare active while idle");
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(NC))
      else $error("store count beyond capacity");
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      do_load |-> !busy)
      else $error("load while busy");
   a_term_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> rsp_last_of_probe)
      else $error("terminator without last mark");

endmodule
